### rtl/brq_pkg.sv
// Shared types, constants and helpers for the byte ring queue with peek.
package brq_pkg;

	// field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 9;
	localparam int unsigned IDX_W  = 9;
	localparam int unsigned FUNC_W = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned OFF_W  = 8;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_ENQ     = 3'd0,
		FN_DEQ     = 3'd1,
		FN_PEEK    = 3'd2,
		FN_CLEAR   = 3'd3,
		FN_REWIND  = 3'd4,
		FN_COMMIT  = 3'd5,
		FN_RESTORE = 3'd6
	} func_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERWRITE = 1'b0,
		REG_SIZE      = 1'b1
	} cfg_reg_t;

	// buffer access for one operation
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	// status reported with each result
	typedef struct packed {
		logic              ok;
		logic              rd_en;
		logic [CNT_W-1:0]  fill;
		logic [CNT_W-1:0]  free;
		logic              q_empty;
		logic              p_empty;
		logic [OFF_W-1:0]  p_off;
	} status_t;

	// clamp a requested size to 1..depth
	function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] qs,
			input int unsigned depth);
		logic [CNT_W-1:0] r;
		if (qs == '0) begin
			r = CNT_W'(1);
		end else if (32'(qs) > depth) begin
			r = CNT_W'(depth);
		end else begin
			r = qs;
		end
		return r;
	endfunction

endpackage

### rtl/brq_ram.sv
// Generic single-clock RAM with one write port and a registered read port.
module brq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/brq_ctrl.sv
// Pointer and count state, configuration registers and per-operation update.
module brq_ctrl import brq_pkg::*; #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [FUNC_W-1:0]     func,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic [CNT_W-1:0]      restore_count,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output mem_req_t              mem_req,
	output status_t               status
);

	logic             ow_q;
	logic [CNT_W-1:0] size_q;
	logic [IDX_W-1:0] head_q, tail_q, peek_q;
	logic [CNT_W-1:0] held_q, prem_q;

	logic [IDX_W-1:0] head_n, tail_n, peek_n;
	logic [CNT_W-1:0] held_n, prem_n;
	logic             ok;
	logic             rd_en;
	logic [IDX_W-1:0] head_adv, tail_adv, peek_adv;
	logic [CNT_W-1:0] r_off;
	logic [IDX_W:0]   r_sum;
	logic [IDX_W-1:0] r_idx;
	logic [IDX_W-1:0] off_full;
	logic             full;
	func_t            fn;

	// index step with wrap at the current size
	function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] sz);
		logic [IDX_W:0] nx;
		nx = {1'b0, idx} + (IDX_W+1)'(1);
		return (nx >= {1'b0, sz}) ? '0 : nx[IDX_W-1:0];
	endfunction

	assign fn       = func_t'(func);
	assign full     = (held_q >= size_q);
	assign head_adv = adv(head_q, size_q);
	assign tail_adv = adv(tail_q, size_q);
	assign peek_adv = adv(peek_q, size_q);

	// restore target: saturated offset, one wrap at most
	assign r_off = (restore_count > held_q) ? held_q : restore_count;
	assign r_sum = {1'b0, head_q} + {1'b0, r_off};
	assign r_idx = (r_sum >= {1'b0, size_q}) ? IDX_W'(r_sum - {1'b0, size_q})
	                                        : r_sum[IDX_W-1:0];

	// next state for the requested operation
	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		peek_n = peek_q;
		held_n = held_q;
		prem_n = prem_q;
		ok     = 1'b0;
		rd_en  = 1'b0;
		mem_req = '0;
		mem_req.wdata = data_byte;
		unique case (fn)
			FN_ENQ: begin
				if (!full || ow_q) begin
					ok = 1'b1;
					mem_req.we    = 1'b1;
					mem_req.waddr = tail_q;
					tail_n = tail_adv;
					if (full) begin
						// oldest byte dropped, peek rewound
						head_n = head_adv;
						peek_n = head_adv;
						prem_n = held_q;
					end else begin
						held_n = held_q + CNT_W'(1);
						prem_n = prem_q + CNT_W'(1);
					end
				end
			end
			FN_DEQ: begin
				if (held_q != '0) begin
					ok = 1'b1;
					rd_en = 1'b1;
					mem_req.re    = 1'b1;
					mem_req.raddr = head_q;
					head_n = head_adv;
					peek_n = head_adv;
					held_n = held_q - CNT_W'(1);
					prem_n = held_q - CNT_W'(1);
				end
			end
			FN_PEEK: begin
				if (prem_q != '0) begin
					ok = 1'b1;
					rd_en = 1'b1;
					mem_req.re    = 1'b1;
					mem_req.raddr = peek_q;
					peek_n = peek_adv;
					prem_n = prem_q - CNT_W'(1);
				end
			end
			FN_CLEAR: begin
				ok = 1'b1;
				head_n = '0;
				tail_n = '0;
				peek_n = '0;
				held_n = '0;
				prem_n = '0;
			end
			FN_REWIND: begin
				ok = 1'b1;
				peek_n = head_q;
				prem_n = held_q;
			end
			FN_COMMIT: begin
				ok = 1'b1;
				head_n = peek_q;
				held_n = prem_q;
			end
			FN_RESTORE: begin
				ok = 1'b1;
				peek_n = r_idx;
				prem_n = held_q - r_off;
			end
			default: begin
				// unused code: report status only
			end
		endcase
	end

	// peek distance from head, both indexes below size
	assign off_full = (peek_n >= head_n) ? (peek_n - head_n)
	                                     : (IDX_W'(size_q) - head_n + peek_n);

	// status after the operation
	always_comb begin
		status.ok      = ok;
		status.rd_en   = rd_en;
		status.fill    = held_n;
		status.free    = size_q - held_n;
		status.q_empty = (held_n == '0);
		status.p_empty = (prem_n == '0);
		status.p_off   = off_full[OFF_W-1:0];
	end

	// state registers; a size write also empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q   <= 1'b0;
			size_q <= eff_size(CNT_W'(256), DEPTH);
			head_q <= '0;
			tail_q <= '0;
			peek_q <= '0;
			held_q <= '0;
			prem_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OVERWRITE: begin
					ow_q <= cfg_data[0];
				end
				REG_SIZE: begin
					size_q <= eff_size(cfg_data, DEPTH);
					head_q <= '0;
					tail_q <= '0;
					peek_q <= '0;
					held_q <= '0;
					prem_q <= '0;
				end
			endcase
		end else if (accept) begin
			head_q <= head_n;
			tail_q <= tail_n;
			peek_q <= peek_n;
			held_q <= held_n;
			prem_q <= prem_n;
		end
	end

	// invariants of the ring state
	a_held_le_size: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= size_q) else $error("held count exceeds size");
	a_prem_le_held: assert property (@(posedge clk) disable iff (!arst_n)
		prem_q <= held_q) else $error("peek remaining exceeds held count");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(head_q) < 32'(size_q)) && (32'(tail_q) < 32'(size_q))
		&& (32'(peek_q) < 32'(size_q))) else $error("index beyond size");

endmodule

### rtl/byte_ring_queue_with_peek_core.sv
// Top level of the byte ring queue with peek cursor.
//
//  channel   handshake                 payload
//  --------  ------------------------  --------------------------------------------
//  command   start, busy (take: !busy) func, data_byte, restore_count
//  result    done (one-cycle strobe)   ok, read_byte, fill_count, free_count,
//                                      queue_empty, peek_empty, peek_offset
//  config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One command per cycle while busy is low; its result strobes in the cycle after it is taken,
// aligned with the buffer RAM's registered read.
// A configuration beat holds busy high for that cycle and wins over a command.
// Reset empties the queue, clears overwrite and sets the size to 256, clamped to the depth.
// The result side has no stall: each result is shown for one cycle only.
module byte_ring_queue_with_peek_core import brq_pkg::*; #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [FUNC_W-1:0]     func,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic [CNT_W-1:0]      restore_count,
	output logic                  done,
	output logic                  ok,
	output logic [BYTE_W-1:0]     read_byte,
	output logic [CNT_W-1:0]      fill_count,
	output logic [CNT_W-1:0]      free_count,
	output logic                  queue_empty,
	output logic                  peek_empty,
	output logic [OFF_W-1:0]      peek_offset,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic              accept;
	mem_req_t          mem_req;
	status_t           status;
	status_t           status_s1;
	logic              valid_s1;
	logic [BYTE_W-1:0] rdata;

	// configuration beats take priority over commands
	assign cfg_ready = 1'b1;
	assign busy      = cfg_valid;
	assign accept    = start && !busy;

	brq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (func),
		.data_byte    (data_byte),
		.restore_count(restore_count),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mem_req      (mem_req),
		.status       (status)
	);

	// byte buffer
	brq_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && mem_req.we),
		.waddr(AW'(mem_req.waddr)),
		.wdata(mem_req.wdata),
		.re   (accept && mem_req.re),
		.raddr(AW'(mem_req.raddr)),
		.rdata(rdata)
	);

	// result stage, aligned with the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
		end
	end

	// result ports
	assign done        = valid_s1;
	assign ok          = status_s1.ok;
	assign read_byte   = status_s1.rd_en ? rdata : '0;
	assign fill_count  = status_s1.fill;
	assign free_count  = status_s1.free;
	assign queue_empty = status_s1.q_empty;
	assign peek_empty  = status_s1.p_empty;
	assign peek_offset = status_s1.p_off;

	// every taken command gives one result on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy && arst_n)) else $error("result strobe mismatch");
	a_read_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (read_byte != '0)) |-> ok) else $error("byte read on a refused beat");
	a_empty_peek: assert property (@(posedge clk) disable iff (!arst_n)
		(done && queue_empty) |-> peek_empty) else $error("peek left on empty queue");

endmodule
